// ===== src/qass_pkg.sv =====
// Shared constants and types for the quote-aware substring search block.
package qass_pkg;

  localparam int unsigned MaxPattern   = 16;
  localparam int unsigned PositionBits = 16;
  localparam int unsigned LenBits      = $clog2(MaxPattern + 1);
  localparam int unsigned SlotBits     = $clog2(MaxPattern);
  localparam int unsigned CfgBits      = 64;
  localparam int unsigned OutBits      = 24;

  localparam logic [7:0] QuoteSingle = 8'h27;
  localparam logic [7:0] QuoteDouble = 8'h22;

  localparam logic [PositionBits-1:0] IndexMax = '1;

  typedef enum logic [1:0] {
    CfgPatternLow    = 2'd0,
    CfgPatternHigh   = 2'd1,
    CfgPatternLength = 2'd2,
    CfgUnused        = 2'd3
  } cfg_index_e;

  typedef logic [7:0] byte_t;

endpackage

// ===== src/quote_aware_substring_search.sv =====
// Streaming search for the first unquoted occurrence of a configured byte pattern.
// The result word for a text byte is registered and appears on the output in the cycle after the byte is accepted.
// Throughput: one text byte per cycle; the input stalls only while a result waits unread.
// The window compare for all pattern lengths is done in parallel in the accepting cycle.
// Reset clears the pattern registers, the quote flags, match state, byte counter and output valid.
// Text state is also cleared after the word marked last; the pattern is kept.
module quote_aware_substring_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // match_now, match_position[15:0], any_match, zero fill
  output logic        m_axis_tlast_o    // text_end
);

  localparam int unsigned NP = qass_pkg::MaxPattern;
  localparam int unsigned PB = qass_pkg::PositionBits;

  logic [63:0] pat_low_q, pat_high_q;
  logic [qass_pkg::LenBits-1:0] pat_len_q;

  qass_pkg::byte_t window_q [NP];
  logic [NP-1:0]   start_q;
  logic            single_q, double_q, found_q;
  logic [PB-1:0]   index_q, found_pos_q;

  logic            out_valid_q;
  logic [23:0]     out_data_q;
  logic            out_last_q;

  qass_pkg::byte_t window_d [NP];
  qass_pkg::byte_t pat      [NP];
  logic [NP-1:0]   start_d;
  logic [NP-1:0]   match_l;
  logic [127:0]    pat_all;
  logic [qass_pkg::LenBits-1:0] len_c;
  logic [qass_pkg::SlotBits-1:0] slot;
  logic            accept, is_quote, hit;
  logic            single_d, double_d, found_d;
  logic [PB-1:0]   found_pos_d, hit_pos;
  logic [PB-1:0]   index_d;
  logic [15:0]     pos_out;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  assign pat_all  = {pat_high_q, pat_low_q};
  assign is_quote = (s_axis_tdata_i == qass_pkg::QuoteSingle) ||
                    (s_axis_tdata_i == qass_pkg::QuoteDouble);
  assign len_c    = (pat_len_q > qass_pkg::LenBits'(NP)) ? qass_pkg::LenBits'(NP) : pat_len_q;
  assign slot     = qass_pkg::SlotBits'(len_c - qass_pkg::LenBits'(1));
  assign hit_pos  = index_q - PB'(slot);

  always_comb begin
    window_d[0] = s_axis_tdata_i;
    start_d[0]  = !is_quote && !single_q && !double_q;
    for (int j = 1; j < NP; j++) begin
      window_d[j] = window_q[j-1];
      start_d[j]  = start_q[j-1];
    end
    for (int k = 0; k < NP; k++) begin
      pat[k] = pat_all[8*k +: 8];
    end
  end

  // match_l[l] is set when a pattern of length l+1 ends at the current byte and its first byte is an unquoted start.
  always_comb begin
    for (int l = 0; l < NP; l++) begin
      match_l[l] = start_d[l];
      for (int k = 0; k <= l; k++) begin
        if (window_d[l-k] != pat[k]) begin
          match_l[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    single_d    = single_q ^ (s_axis_tdata_i == qass_pkg::QuoteSingle);
    double_d    = double_q ^ (s_axis_tdata_i == qass_pkg::QuoteDouble);
    hit         = 1'b0;
    found_d     = found_q;
    found_pos_d = found_pos_q;
    if (!found_q) begin
      if (len_c == '0) begin
        hit         = 1'b1;
        found_d     = 1'b1;
        found_pos_d = '0;
      end else if (match_l[slot]) begin
        hit         = 1'b1;
        found_d     = 1'b1;
        found_pos_d = hit_pos;
      end
    end
    index_d = (index_q < qass_pkg::IndexMax) ? index_q + PB'(1) : index_q;
    pos_out = found_d ? 16'(found_pos_d) : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (qass_pkg::cfg_index_e'(cfg_index_i))
        qass_pkg::CfgPatternLow:    pat_low_q  <= cfg_data_i;
        qass_pkg::CfgPatternHigh:   pat_high_q <= cfg_data_i;
        qass_pkg::CfgPatternLength: pat_len_q  <= cfg_data_i[qass_pkg::LenBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      single_q    <= 1'b0;
      double_q    <= 1'b0;
      found_q     <= 1'b0;
      found_pos_q <= '0;
      index_q     <= '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        start_q     <= '0;
        single_q    <= 1'b0;
        double_q    <= 1'b0;
        found_q     <= 1'b0;
        found_pos_q <= '0;
        index_q     <= '0;
      end else begin
        start_q     <= start_d;
        single_q    <= single_d;
        double_q    <= double_d;
        found_q     <= found_d;
        found_pos_q <= found_pos_d;
        index_q     <= index_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < NP; j++) begin
        window_q[j] <= window_d[j];
      end
      out_data_q <= {6'd0, found_d, pos_out, hit};
      out_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |=> !found_q && index_q == '0 && start_q == '0)
    else $error("Text state not cleared after the last word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !hit)
    else $error("Second match reported within one text.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s_axis_tlast_i && index_q == qass_pkg::IndexMax |=> index_q == qass_pkg::IndexMax)
    else $error("Byte index left saturation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && out_data_q[0] == $past(hit) && out_data_q[17] == $past(found_d))
    else $error("Result word does not match the accepted byte.");
`endif

endmodule

// ===== dv/tb_quote_aware_substring_search.sv =====
// Self-checking testbench for the quote-aware substring search block.
module tb_quote_aware_substring_search;

  localparam int CycleLimit = 1_000_000;
  localparam int PrintLimit = 30;
  localparam qass_pkg::byte_t ChA = "a";
  localparam qass_pkg::byte_t ChB = "b";

  typedef struct packed {
    qass_pkg::byte_t value;
    bit              last;
  } text_word_t;

  typedef struct packed {
    bit                              match_now;
    bit [qass_pkg::PositionBits-1:0] position;
    bit                              any_match;
    bit                              text_end;
  } search_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  qass_pkg::cfg_index_e cfg_index = qass_pkg::CfgPatternLow;
  logic [qass_pkg::CfgBits-1:0] cfg_data = '0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [7:0]        s_data = '0;
  logic              s_last = 1'b0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [qass_pkg::OutBits-1:0] m_data;
  logic              m_last;

  quote_aware_substring_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  // Pattern registers and per-text search state of the predictor.
  logic [63:0]       pat_lo = '0;
  logic [63:0]       pat_hi = '0;
  logic [qass_pkg::LenBits-1:0] pat_len = '0;
  qass_pkg::byte_t   text_win [qass_pkg::MaxPattern];
  bit                start_ok [qass_pkg::MaxPattern];
  bit                sq_open;
  bit                dq_open;
  logic [qass_pkg::PositionBits-1:0] text_pos;
  bit                hit_seen;
  logic [qass_pkg::PositionBits-1:0] hit_pos;

  text_word_t        pending_words[$];
  search_result_t    expected_results[$];
  text_word_t        next_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int words_scanned = 0;
  int results_checked = 0;
  int texts_checked = 0;
  int matches_checked = 0;
  int hold_cycles_seen = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic qass_pkg::byte_t pattern_byte(int unsigned k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_text_state();
    for (int k = 0; k < qass_pkg::MaxPattern; k++) begin
      text_win[k] = '0;
      start_ok[k] = 1'b0;
    end
    sq_open = 1'b0;
    dq_open = 1'b0;
    text_pos = '0;
    hit_seen = 1'b0;
    hit_pos = '0;
  endfunction

  function automatic void scan_text_byte(qass_pkg::byte_t b, bit last);
    int unsigned    n;
    bit             equal;
    bit             quote;
    search_result_t r;
    n = (pat_len > qass_pkg::MaxPattern) ? qass_pkg::MaxPattern : pat_len;
    quote = (b == qass_pkg::QuoteSingle) || (b == qass_pkg::QuoteDouble);
    for (int k = qass_pkg::MaxPattern - 1; k > 0; k--) begin
      text_win[k] = text_win[k-1];
      start_ok[k] = start_ok[k-1];
    end
    text_win[0] = b;
    start_ok[0] = !quote && !sq_open && !dq_open;
    if (b == qass_pkg::QuoteSingle) begin
      sq_open = !sq_open;
    end else if (b == qass_pkg::QuoteDouble) begin
      dq_open = !dq_open;
    end
    r = '0;
    if (!hit_seen) begin
      if (n == 0) begin
        hit_seen = 1'b1;
        hit_pos = '0;
        r.match_now = 1'b1;
      end else if (start_ok[n-1]) begin
        equal = 1'b1;
        for (int k = 0; k < n; k++) begin
          if (text_win[n-1-k] != pattern_byte(k)) equal = 1'b0;
        end
        if (equal) begin
          hit_seen = 1'b1;
          hit_pos = text_pos - qass_pkg::PositionBits'(n - 1);
          r.match_now = 1'b1;
        end
      end
    end
    r.position = hit_seen ? hit_pos : '0;
    r.any_match = hit_seen;
    r.text_end = last;
    expected_results.push_back(r);
    if (text_pos != qass_pkg::IndexMax) text_pos++;
    if (last) clear_text_state();
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("mismatch at result word %0d: %s", results_checked, what);
    end
  endtask

  // Driver: a word stays on the bus until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        s_valid <= 1'b1;
        s_data <= next_word.value;
        s_last <= next_word.last;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver with random stalls and an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_cycles_seen++;
      m_ready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on every accepted text word and checks every result word.
  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        scan_text_byte(s_data, s_last);
        words_scanned++;
      end
      if (m_valid && m_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no pending expectation");
        end else begin
          want = expected_results.pop_front();
          if (m_data[0] !== want.match_now)
            report_mismatch($sformatf("match_now %b, expected %b", m_data[0], want.match_now));
          if (m_data[16:1] !== want.position)
            report_mismatch($sformatf("match_position %0d, expected %0d",
                                      m_data[16:1], want.position));
          if (m_data[17] !== want.any_match)
            report_mismatch($sformatf("any_match %b, expected %b", m_data[17], want.any_match));
          if (m_data[qass_pkg::OutBits-1:18] !== '0)
            report_mismatch($sformatf("fill bits %b, expected zero",
                                      m_data[qass_pkg::OutBits-1:18]));
          if (m_last !== want.text_end)
            report_mismatch($sformatf("text_end %b, expected %b", m_last, want.text_end));
          if (want.text_end) texts_checked++;
          if (want.match_now) matches_checked++;
        end
        results_checked++;
      end
    end
  end

  task automatic write_reg(qass_pkg::cfg_index_e idx, logic [qass_pkg::CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      qass_pkg::CfgPatternLow:    pat_lo = val;
      qass_pkg::CfgPatternHigh:   pat_hi = val;
      qass_pkg::CfgPatternLength: pat_len = val[qass_pkg::LenBits-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_word(qass_pkg::byte_t b, bit last);
    text_word_t w;
    w.value = b;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  function automatic qass_pkg::byte_t pick_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return ChA + qass_pkg::byte_t'($urandom_range(2));
      4:          return qass_pkg::QuoteSingle;
      5:          return qass_pkg::QuoteDouble;
      6:          return 8'h00;
      7:          return 8'hFF;
      default:    return qass_pkg::byte_t'($urandom_range(255));
    endcase
  endfunction

  // Builds one text from pattern copies, quotes and other bytes, or from random bytes only, and queues it.
  function automatic int add_text();
    int unsigned n;
    int unsigned plen;
    int unsigned r;
    int          spot;
    qass_pkg::byte_t body[$];
    n = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
    plen = (pat_len > qass_pkg::MaxPattern) ? qass_pkg::MaxPattern : pat_len;
    if ($urandom_range(99) < 12) begin
      repeat (n) body.push_back(qass_pkg::byte_t'($urandom_range(255)));
    end else begin
      while (body.size() < n) begin
        r = $urandom_range(99);
        if (r < 25) begin
          for (int k = 0; k < plen; k++) body.push_back(pattern_byte(k));
          if (plen != 0 && $urandom_range(3) == 0) begin
            spot = body.size() - 1 - $urandom_range(plen - 1);
            body[spot] = body[spot] ^ qass_pkg::byte_t'(1 << $urandom_range(7));
          end
        end else if (r < 35) begin
          body.push_back($urandom_range(1) ? qass_pkg::QuoteSingle : qass_pkg::QuoteDouble);
        end else if (r < 90) begin
          body.push_back(pick_byte());
        end else begin
          body.push_back(qass_pkg::byte_t'($urandom_range(255)));
        end
      end
    end
    for (int k = 0; k < body.size(); k++) push_word(body[k], k == body.size() - 1);
    return body.size();
  endfunction

  task automatic random_pattern();
    logic [127:0] pat;
    int unsigned  n;
    case ($urandom_range(19))
      0:                 n = 0;
      1:                 n = qass_pkg::MaxPattern;
      2:                 n = $urandom_range(31, 17);
      3, 4, 5:           n = $urandom_range(16, 9);
      6, 7, 8, 9, 10:    n = $urandom_range(8, 4);
      default:           n = $urandom_range(3, 1);
    endcase
    for (int k = 0; k < qass_pkg::MaxPattern; k++) pat[8*k +: 8] = pick_byte();
    if ($urandom_range(9) == 0) pat[63:0] = {$urandom, $urandom};
    if ($urandom_range(9) == 0) pat[127:64] = {$urandom, $urandom};
    write_reg(qass_pkg::CfgPatternLow, pat[63:0]);
    write_reg(qass_pkg::CfgPatternHigh, pat[127:64]);
    write_reg(qass_pkg::CfgPatternLength, qass_pkg::CfgBits'(n));
  endtask

  task automatic run_phase(int idle, int stall, int hold, int n_items);
    int queued;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int c = 0; c < 3; c++) begin
      drain();
      random_pattern();
      queued = 0;
      while (queued < n_items / 3) queued += add_text();
      if (c == 0 && hold > 0) hold_request = hold;
    end
    drain();
  endtask

  initial begin
    clear_text_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern matches on the first byte.
    write_reg(qass_pkg::CfgPatternLength, 64'd0);
    push_word(ChA, 1'b0);
    push_word(ChB, 1'b1);
    drain();

    // A start inside double quotes is refused; the later unquoted one is taken.
    write_reg(qass_pkg::CfgPatternLow, {48'h0, ChB, ChA});
    write_reg(qass_pkg::CfgPatternLength, 64'd2);
    push_word(qass_pkg::QuoteDouble, 1'b0);
    push_word(ChA, 1'b0);
    push_word(ChB, 1'b0);
    push_word(qass_pkg::QuoteDouble, 1'b0);
    push_word(ChA, 1'b0);
    push_word(ChB, 1'b1);
    drain();

    // Compared bytes may run into a quote.
    write_reg(qass_pkg::CfgPatternLow, {48'h0, qass_pkg::QuoteSingle, ChA});
    push_word(ChA, 1'b0);
    push_word(qass_pkg::QuoteSingle, 1'b1);
    drain();

    // Full-width all-ones pattern with a length above the maximum.
    write_reg(qass_pkg::CfgPatternLow, '1);
    write_reg(qass_pkg::CfgPatternHigh, '1);
    write_reg(qass_pkg::CfgPatternLength, 64'd20);
    repeat (qass_pkg::MaxPattern - 1) push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b1);
    drain();

    run_phase(0, 0, 0, 320);
    run_phase(68, 0, 0, 320);
    run_phase(0, 68, 400, 320);
    run_phase(32, 32, 0, 320);
    repeat (8) @(posedge clk_i);

    $display("scanned %0d text words in %0d texts, %0d first matches found",
             words_scanned, texts_checked, matches_checked);
    $display("checked %0d result words across four flow-control phases, %0d hold-off cycles",
             results_checked, hold_cycles_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
